[hdl/awac_pkg.sv]
// Shared types, constants and helpers for the alpha-weighted average color block.
`timescale 1ns / 1ps
`default_nettype none
package awac_pkg;

    localparam int SUM_W = 30;
    localparam int D_W = SUM_W - 7;
    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam int PROD_W = 16;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [7:0] FULL_ALPHA = 8'd255;
    localparam logic [7:0] CHAN_MAX = 8'd255;

    // floor(x / 255) for x below 2^30 is (x * RECIP_255) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 38;
    localparam int RECIP_W = 31;
    localparam logic [RECIP_W-1:0] RECIP_255 = 31'h40404041;

    typedef enum logic [1:0] {
        SEL_D,
        SEL_R,
        SEL_G,
        SEL_B
    } div_sel_t;

    typedef struct packed {
        logic     pix_take;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_q;
        logic     out_load;
        logic     clear;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic d_zero;
        logic out_free;
    } st_t;

    // floor(x / 255) for any product of two 8-bit values (x up to 255 * 255)
    function automatic logic [7:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {9'd0, x[PROD_W-1:8]} + {{PROD_W{1'b0}}, 1'b1};
        return t[PROD_W-1:8];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [7:0] inc);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {{(SUM_W - 7){1'b0}}, inc};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hdl/awac_ctrl.sv]
// Sequencer for pixel intake, the four divisions and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module awac_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    input  awac_pkg::st_t      st,
    output awac_pkg::cmd_t     cmd
);
    import awac_pkg::*;

    typedef enum logic [2:0] {
        ACCUM,
        FLUSH,
        LOAD_D,
        DIV_START,
        DIV_WAIT,
        FINISH
    } state_t;

    state_t   state_reg;
    div_sel_t sel_reg;
    logic     s_tready_reg;
    logic     take;

    assign take = s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ACCUM;
            sel_reg      <= SEL_D;
            s_tready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ACCUM: begin
                    if (take && s_tlast) begin
                        state_reg    <= FLUSH;
                        s_tready_reg <= 1'b0;
                    end
                end
                FLUSH: begin
                    state_reg <= LOAD_D;
                    sel_reg   <= SEL_D;
                end
                LOAD_D: begin
                    if (st.d_zero) begin
                        state_reg <= FINISH;
                    end else begin
                        state_reg <= DIV_START;
                        sel_reg   <= SEL_R;
                    end
                end
                DIV_START: begin
                    state_reg <= DIV_WAIT;
                end
                DIV_WAIT: begin
                    if (!st.div_busy) begin
                        if (sel_reg == SEL_B) begin
                            state_reg <= FINISH;
                        end else begin
                            state_reg <= DIV_START;
                            sel_reg   <= div_sel_t'(sel_reg + 2'd1);
                        end
                    end
                end
                FINISH: begin
                    if (st.out_free) begin
                        state_reg    <= ACCUM;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ACCUM;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        cmd.pix_take  = take;
        cmd.div_start = (state_reg == DIV_START);
        cmd.load_q    = ((state_reg == DIV_WAIT) && !st.div_busy) || (state_reg == LOAD_D);
        cmd.out_load  = (state_reg == FINISH) && st.out_free;
        cmd.clear     = cmd.out_load;
    end

endmodule
`default_nettype wire

[hdl/awac_dp.sv]
// Datapath: weighting pipeline, accumulators, shared serial divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module awac_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [31:0]   s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tuser,
    input  awac_pkg::cmd_t     cmd,
    output awac_pkg::st_t      st
);
    import awac_pkg::*;

    // weighting stage
    logic              p_valid_reg;
    logic [PROD_W-1:0] p_r_reg, p_g_reg, p_b_reg;
    logic [7:0]        p_a_reg;

    logic [SUM_W-1:0]  r_sum_reg, g_sum_reg, b_sum_reg, a_sum_reg;

    // alpha_sum / 255 by reciprocal multiply
    logic [SUM_W+RECIP_W-1:0] d_prod;
    logic [D_W-1:0]           d_calc;
    logic                     d_zero;

    // serial divider
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic [SUM_W:0]   trial;
    logic             fits;

    logic [D_W-1:0]   d_reg;
    logic             nocov_reg;
    logic [7:0]       q_r_reg, q_g_reg, q_b_reg;
    logic [7:0]       q_sat;

    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;
    logic             m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= cmd.pix_take;
        end
        if (cmd.pix_take) begin
            p_r_reg <= s_tdata[7:0] * s_tdata[31:24];
            p_g_reg <= s_tdata[15:8] * s_tdata[31:24];
            p_b_reg <= s_tdata[23:16] * s_tdata[31:24];
            p_a_reg <= s_tdata[31:24];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            r_sum_reg <= '0;
            g_sum_reg <= '0;
            b_sum_reg <= '0;
            a_sum_reg <= '0;
        end else if (p_valid_reg) begin
            r_sum_reg <= sat_add(r_sum_reg, div255(p_r_reg));
            g_sum_reg <= sat_add(g_sum_reg, div255(p_g_reg));
            b_sum_reg <= sat_add(b_sum_reg, div255(p_b_reg));
            a_sum_reg <= sat_add(a_sum_reg, p_a_reg);
        end
    end

    assign d_prod = {{RECIP_W{1'b0}}, a_sum_reg} * {{SUM_W{1'b0}}, RECIP_255};
    assign d_calc = d_prod[RECIP_SHIFT+D_W-1:RECIP_SHIFT];
    assign d_zero = a_sum_reg < {{(SUM_W - 8){1'b0}}, FULL_ALPHA};

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.div_start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SUM_W);
            rem_reg  <= '0;
            case (cmd.div_sel)
                SEL_R: begin
                    quo_reg <= r_sum_reg;
                    dvs_reg <= {{(SUM_W - D_W){1'b0}}, d_reg};
                end
                SEL_G: begin
                    quo_reg <= g_sum_reg;
                    dvs_reg <= {{(SUM_W - D_W){1'b0}}, d_reg};
                end
                SEL_B: begin
                    quo_reg <= b_sum_reg;
                    dvs_reg <= {{(SUM_W - D_W){1'b0}}, d_reg};
                end
                default: begin
                    quo_reg <= '0;
                    dvs_reg <= '1;
                end
            endcase
        end else if (busy_reg) begin
            rem_reg  <= fits ? SUM_W'(trial - {1'b0, dvs_reg}) : trial[SUM_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], fits};
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    assign q_sat = (|quo_reg[SUM_W-1:8]) ? CHAN_MAX : quo_reg[7:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_q) begin
            case (cmd.div_sel)
                SEL_D: begin
                    d_reg     <= d_calc;
                    nocov_reg <= d_zero;
                end
                SEL_R:   q_r_reg <= q_sat;
                SEL_G:   q_g_reg <= q_sat;
                SEL_B:   q_b_reg <= q_sat;
                default: d_reg   <= d_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= nocov_reg ? 24'd0 : {q_b_reg, q_g_reg, q_r_reg};
            m_tuser_reg <= nocov_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign st.div_busy = busy_reg;
    assign st.d_zero   = d_zero;
    assign st.out_free = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

[hdl/alpha_weighted_average_color_top.sv]
// Top level of the alpha-weighted average color block.
//
// Input: one RGBA8 pixel per request on s_t*, s_tlast on the final pixel of
// an image. Pixels are taken one per cycle while an image streams in.
// After the last pixel, s_tready stays low while the result is formed:
// a flush state, alpha_sum / 255 by reciprocal multiply, then a 30-step
// serial divider divides each color sum by that quotient, one at a time.
// The color divisions are skipped when the coverage is zero; s_tready
// returns with m_tvalid.
// Output: one request per image on m_t*, colors saturated to 255;
// m_tuser flags zero coverage, with all colors zero.
// The result sits in an output register; the next image is accepted while it
// waits, and a stalled receiver only holds the block when a second result is
// ready before the first is taken.
// Reset (aresetn low, synchronous) clears all sums and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module alpha_weighted_average_color_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red, green, blue, alpha
    input  wire logic        s_tlast,   // last_pixel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // avg_red, avg_green, avg_blue
    output logic             m_tuser    // no_coverage
);
    import awac_pkg::*;

    cmd_t cmd;
    st_t  st;

    awac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    awac_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

endmodule
`default_nettype wire

[hdl/awac_checker.sv]
// Port-level checks for the alpha-weighted average color top, bound to it.
`timescale 1ns / 1ps
`default_nettype none
module awac_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_nocov_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("no coverage result carries nonzero color");

    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("pixel intake open right after last pixel");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind alpha_weighted_average_color_top awac_checker u_awac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
